>>> src/hsv3d_pkg.sv
// shared constants, types and helpers for the hsv 3d histogram
`default_nettype none
package hsv3d_pkg;

    // default histogram geometry
    localparam int HUE_BINS_DEF   = 18;
    localparam int SAT_BINS_DEF   = 16;
    localparam int VAL_BINS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 17;

    // hue range and byte range of the pixel axes
    localparam int HUE_RANGE  = 180;
    localparam int BYTE_RANGE = 256;

    // fixed field widths of the stream payload
    localparam int SAMPLE_W     = 8;
    localparam int BIN_COUNT_W  = 17;
    localparam int BIN_NUMBER_W = 13;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 32;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // reciprocal scaling for division by a constant step
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = RECIP_W + SAMPLE_W;

    // command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } back_state_t;

    // sample divided by step, with recip = floor(2^shift / step) + 1
    function automatic logic [SAMPLE_W-1:0] scale_index(
        input logic [SAMPLE_W-1:0] sample,
        input logic [RECIP_W-1:0]  recip
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sample) * PROD_W'(recip);
        return prod[RECIP_SHIFT +: SAMPLE_W];
    endfunction

endpackage
`default_nettype wire

>>> src/hsv3d_front.sv
// front part: takes pixel and readout items, computes the flat bin address
`default_nettype none
module hsv3d_front #(
    parameter int HUE_BINS = hsv3d_pkg::HUE_BINS_DEF,
    parameter int SAT_BINS = hsv3d_pkg::SAT_BINS_DEF,
    parameter int VAL_BINS = hsv3d_pkg::VAL_BINS_DEF,
    parameter int ADDR_W   = 13
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          busy,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_cmd,
    input  wire logic [hsv3d_pkg::SAMPLE_W-1:0] in_hue,
    input  wire logic [hsv3d_pkg::SAMPLE_W-1:0] in_sat,
    input  wire logic [hsv3d_pkg::SAMPLE_W-1:0] in_val,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic                               push_cmd,
    output logic [ADDR_W-1:0]                  push_addr
);

    localparam int HUE_STEP = hsv3d_pkg::HUE_RANGE / HUE_BINS;
    localparam int SAT_STEP = hsv3d_pkg::BYTE_RANGE / SAT_BINS;
    localparam int VAL_STEP = hsv3d_pkg::BYTE_RANGE / VAL_BINS;
    localparam int HUE_RECIP = (1 << hsv3d_pkg::RECIP_SHIFT) / HUE_STEP + 1;
    localparam int SAT_RECIP = (1 << hsv3d_pkg::RECIP_SHIFT) / SAT_STEP + 1;
    localparam int VAL_RECIP = (1 << hsv3d_pkg::RECIP_SHIFT) / VAL_STEP + 1;
    localparam int SW = hsv3d_pkg::SAMPLE_W;
    localparam int IW = SW + 1;

    logic          a_valid_reg, a_valid_next;
    logic          a_cmd_reg;
    logic [SW-1:0] a_hue_reg, a_sat_reg, a_val_reg;
    logic          take;
    logic [SW-1:0] q_hue, q_sat, q_val;
    logic [SW-1:0] h_idx, s_idx, v_idx;

    // scaled indices before clamping
    assign q_hue = hsv3d_pkg::scale_index(in_hue, hsv3d_pkg::RECIP_W'(HUE_RECIP));
    assign q_sat = hsv3d_pkg::scale_index(in_sat, hsv3d_pkg::RECIP_W'(SAT_RECIP));
    assign q_val = hsv3d_pkg::scale_index(in_val, hsv3d_pkg::RECIP_W'(VAL_RECIP));

    assign in_ready   = !busy && (!a_valid_reg || push_ready);
    assign take       = in_valid && in_ready;
    assign push_valid = a_valid_reg;
    assign push_cmd   = a_cmd_reg;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (take)
        begin
            a_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // clamp to last bin of each axis
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_cmd_reg <= in_cmd;
            a_hue_reg <= (IW'(q_hue) >= IW'(HUE_BINS)) ? SW'(HUE_BINS - 1) : q_hue;
            a_sat_reg <= (IW'(q_sat) >= IW'(SAT_BINS)) ? SW'(SAT_BINS - 1) : q_sat;
            a_val_reg <= (IW'(q_val) >= IW'(VAL_BINS)) ? SW'(VAL_BINS - 1) : q_val;
        end
    end

    assign h_idx = a_hue_reg;
    assign s_idx = a_sat_reg;
    assign v_idx = a_val_reg;

    assign push_addr = ADDR_W'(h_idx) * ADDR_W'(SAT_BINS * VAL_BINS)
                     + ADDR_W'(s_idx) * ADDR_W'(VAL_BINS)
                     + ADDR_W'(v_idx);

endmodule
`default_nettype wire

>>> src/hsv3d_queue.sv
// short command queue between the front and the back
`default_nettype none
module hsv3d_queue #(
    parameter int ADDR_W = 13,
    parameter int DEPTH  = hsv3d_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic              push_cmd,
    input  wire logic [ADDR_W-1:0] push_addr,
    output logic                   pop_valid,
    input  wire logic              pop,
    output logic                   pop_cmd,
    output logic [ADDR_W-1:0]      pop_addr
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic              cmd_q  [DEPTH];
    logic [ADDR_W-1:0] addr_q [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = cmd_q[rd_ptr_reg];
    assign pop_addr   = addr_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_q[wr_ptr_reg]  <= push_cmd;
            addr_q[wr_ptr_reg] <= push_addr;
        end
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count past depth");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !do_push) |=> (count_reg == '0))
        else $error("queue count moved without a push");
`endif

endmodule
`default_nettype wire

>>> src/hsv3d_back.sv
// back part: bin memory, read-modify-write, readout pointer and result register
`default_nettype none
module hsv3d_back #(
    parameter int TOTAL_BINS = 4608,
    parameter int COUNT_BITS = hsv3d_pkg::COUNT_BITS_DEF,
    parameter int ADDR_W     = 13
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    output logic                                    busy,
    input  wire logic                               q_valid,
    output logic                                    q_pop,
    input  wire logic                               q_cmd,
    input  wire logic [ADDR_W-1:0]                  q_addr,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [hsv3d_pkg::BIN_COUNT_W-1:0]       out_count,
    output logic [hsv3d_pkg::BIN_NUMBER_W-1:0]      out_number,
    output logic                                    out_last
);

    localparam int CEXT_W = (COUNT_BITS > hsv3d_pkg::BIN_COUNT_W) ?
                            COUNT_BITS : hsv3d_pkg::BIN_COUNT_W;
    localparam int AEXT_W = (ADDR_W > hsv3d_pkg::BIN_NUMBER_W) ?
                            ADDR_W : hsv3d_pkg::BIN_NUMBER_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL_BINS - 1);

    hsv3d_pkg::back_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] mem [TOTAL_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic                  op_cmd_reg;
    logic [ADDR_W-1:0]     op_addr_reg;
    logic [ADDR_W-1:0]     sel_addr;
    logic                  mem_re, mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  out_load;
    logic                  out_valid_reg, out_valid_next;
    logic [CEXT_W-1:0]     cnt_ext;
    logic [AEXT_W-1:0]     addr_ext;

    assign busy     = (state_reg == hsv3d_pkg::ST_CLEAR);
    assign sel_addr = (q_cmd == hsv3d_pkg::CMD_READ) ? ptr_reg : q_addr;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ptr_next     = ptr_reg;
        q_pop        = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = op_addr_reg;
        mem_wdata    = '0;
        out_load     = 1'b0;
        case (state_reg)
            hsv3d_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = hsv3d_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            hsv3d_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    state_next = hsv3d_pkg::ST_UPDATE;
                    if (q_cmd == hsv3d_pkg::CMD_READ)
                    begin
                        ptr_next = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + 1'b1;
                    end
                end
            end
            hsv3d_pkg::ST_UPDATE:
            begin
                if (op_cmd_reg == hsv3d_pkg::CMD_ACCUM)
                begin
                    // saturating increment
                    mem_we     = 1'b1;
                    mem_wdata  = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
                    state_next = hsv3d_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    // clear on read
                    mem_we     = 1'b1;
                    out_load   = 1'b1;
                    state_next = hsv3d_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hsv3d_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsv3d_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_cmd_reg  <= q_cmd;
            op_addr_reg <= sel_addr;
        end
    end

    // bin memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[sel_addr];
        end
    end

    assign cnt_ext  = CEXT_W'(rd_data_reg);
    assign addr_ext = AEXT_W'(op_addr_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count  <= cnt_ext[hsv3d_pkg::BIN_COUNT_W-1:0];
            out_number <= addr_ext[hsv3d_pkg::BIN_NUMBER_W-1:0];
            out_last   <= (op_addr_reg == LAST_ADDR);
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsv3d_pkg::ST_IDLE) |-> !mem_we)
        else $error("memory written while idle");
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= LAST_ADDR)
        else $error("readout pointer past last bin");
    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsv3d_pkg::ST_CLEAR && clr_cnt_reg == LAST_ADDR)
        |=> (state_reg == hsv3d_pkg::ST_IDLE))
        else $error("clearing pass did not end");
`endif

endmodule
`default_nettype wire

>>> src/hsv_3d_histogram_top.sv
// top level of the joint hue, saturation and value histogram
// a readout item passes the front register, the queue, the memory read and result registers
// the back takes a new item only once the read-modify-write of the last one on the bin memory is done
// unless clearing or full, a 4-entry queue lets short bursts in at one item per cycle
// reset: asynchronous, active low; then a clearing pass over all TOTAL_BINS bins
// (4608 with the default geometry) zeroes them while s_tready stays low
`default_nettype none
module hsv_3d_histogram_top #(
    parameter int HUE_BINS   = hsv3d_pkg::HUE_BINS_DEF,
    parameter int SAT_BINS   = hsv3d_pkg::SAT_BINS_DEF,
    parameter int VAL_BINS   = hsv3d_pkg::VAL_BINS_DEF,
    parameter int COUNT_BITS = hsv3d_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // hue [7:0], saturation [15:8], value [23:16]
    input  wire logic [hsv3d_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command [0]: accumulate pixel or read out next bin
    input  wire logic [0:0]                           s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // bin_count [16:0], bin_number [29:17], zero [31:30]
    output logic [hsv3d_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // last_bin
    output logic                                      m_tlast
);

    // flat bin count and address width
    localparam int TOTAL_BINS = HUE_BINS * SAT_BINS * VAL_BINS;
    localparam int ADDR_W     = (TOTAL_BINS > 1) ? $clog2(TOTAL_BINS) : 1;
    localparam int SW         = hsv3d_pkg::SAMPLE_W;
    localparam int PAD_W      = hsv3d_pkg::OUT_TDATA_W - hsv3d_pkg::BIN_COUNT_W
                              - hsv3d_pkg::BIN_NUMBER_W;

    logic                                 busy;
    logic                                 push_valid, push_ready, push_cmd;
    logic [ADDR_W-1:0]                    push_addr;
    logic                                 q_valid, q_pop, q_cmd;
    logic [ADDR_W-1:0]                    q_addr;
    logic [hsv3d_pkg::BIN_COUNT_W-1:0]    out_count;
    logic [hsv3d_pkg::BIN_NUMBER_W-1:0]   out_number;

    // front: clamps and flattens pixel coordinates into a bin address
    hsv3d_front #(
        .HUE_BINS (HUE_BINS),
        .SAT_BINS (SAT_BINS),
        .VAL_BINS (VAL_BINS),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy       (busy),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_hue     (s_tdata[0 +: SW]),
        .in_sat     (s_tdata[SW +: SW]),
        .in_val     (s_tdata[2*SW +: SW]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr)
    );

    // queue lets the front keep taking items while the back works
    hsv3d_queue #(
        .ADDR_W (ADDR_W),
        .DEPTH  (hsv3d_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd),
        .pop_addr   (q_addr)
    );

    // back: bin memory updates, readout and result register
    hsv3d_back #(
        .TOTAL_BINS (TOTAL_BINS),
        .COUNT_BITS (COUNT_BITS),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd),
        .q_addr     (q_addr),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_count  (out_count),
        .out_number (out_number),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_number, out_count};

endmodule
`default_nettype wire
